// ===== src/inter_device_delay_switch_assert.svh =====
// Assertion macros for the inter-device delay switch.
// Included by modules that check their own control logic; needs clock and reset in scope.
`ifndef INTER_DEVICE_DELAY_SWITCH_ASSERT_SVH
`define INTER_DEVICE_DELAY_SWITCH_ASSERT_SVH
`ifndef SYNTHESIS
`define IDDS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define IDDS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define IDDS_ASSERT_SAME(lbl, ante, cons, msg)
`define IDDS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/idds_pkg.sv =====
// Types and codes shared by the inter-device delay switch modules.
// No dependencies.
package idds_pkg;

   localparam int CFG_BITS       = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int STAMP_BITS     = 17;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACCEPT_CYCLES  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_CYCLES  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LATENCY_CYCLES = 2'd2;

   localparam logic MODE_OFFER = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   localparam logic KIND_OFFER = 1'b0;
   localparam logic KIND_SLOT  = 1'b1;

   localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
   localparam logic [1:0] STATUS_DROPPED  = 2'd1;
   localparam logic [1:0] STATUS_REFUSED  = 2'd2;

   typedef struct packed {
      logic        mode;
      logic [63:0] beat_data;
      logic [1:0]  target_device;
      logic [7:0]  local_node;
      logic [7:0]  remote_node;
      logic [15:0] user_bits;
      logic        last_beat;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  offer_status;
      logic [1:0]  port;
      logic        out_valid;
      logic [63:0] out_data;
      logic [7:0]  out_local_node;
      logic [15:0] out_user;
      logic        out_last;
      logic        end_of_run;
   } rsp_type;

endpackage

// ===== src/idds_ram.sv =====
// Single-port-write, single-port-read queue storage with registered read data.
// Standalone; used by the inter-device delay switch top level.
module idds_ram #(
   parameter int WIDTH = 106,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/idds_age_check.sv =====
// Age compare unit: elapsed ticks since enqueue, saturated, against the latency setting.
// Depends on idds_pkg.
module idds_age_check (
   input  logic [idds_pkg::STAMP_BITS-1:0] now,
   input  logic [idds_pkg::STAMP_BITS-1:0] stamp,
   input  logic [idds_pkg::CFG_BITS-1:0]   latency,
   output logic                            eligible
);

   import idds_pkg::*;

   logic [STAMP_BITS-1:0] elapsed;

   assign elapsed  = now - stamp;
   assign eligible = (elapsed[STAMP_BITS-1:CFG_BITS] != '0)
                  || (elapsed[CFG_BITS-1:0] >= latency);

endmodule

// ===== src/inter_device_delay_switch.sv =====
// Inter-device delay switch: per-device beat queues with bandwidth window and delivery latency.
// Depends on idds_pkg, idds_ram, idds_age_check and inter_device_delay_switch_assert.svh.
//
// Usage: req_valid/req_ready carry one word per item. mode offer queues a beat into the
// FIFO of its target device (if the bandwidth window is open and the FIFO has room) and
// returns one status word. mode tick ages all queued beats, advances the window counter
// and returns NUM_DEVICES slot words in port order, the last marked by end_of_run.
// Results leave through a single output register on rsp_valid/rsp_ready.
// Timing: an offer occupies S_OFFER; a tick occupies S_TREAD then S_TEMIT per device, set by
// the single queue memory read port (registered data) and the one shared age compare
// visited once per device. req_ready is high only between items.
// Results: the offer status is loaded into the output register from S_OFFER, and
// tick slot k is loaded from S_TEMIT after the S_TREAD read of device k.
// When rsp_ready is low with a result held, the sequencer waits before emitting the
// next result; nothing is lost or repeated.
// Reset: all queues empty, window counter 0, accept_cycles 1, window_cycles 1,
// latency_cycles 0. Queue storage is not cleared; no clearing pass is needed.
// csr_we writes register csr_index with csr_wdata in the same cycle.
`include "inter_device_delay_switch_assert.svh"

module inter_device_delay_switch #(
   parameter int NUM_DEVICES = 4,
   parameter int QUEUE_DEPTH = 16,
   parameter int DATA_BITS   = 64,
   parameter int NODE_BITS   = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  idds_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output idds_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [idds_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [idds_pkg::CFG_BITS-1:0]       csr_wdata
);

   import idds_pkg::*;

   localparam int DEV_W     = $clog2(NUM_DEVICES);
   localparam int IDX_W     = $clog2(QUEUE_DEPTH);
   localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int DEPTH     = NUM_DEVICES * QUEUE_DEPTH;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int USER_LSB  = DATA_BITS;
   localparam int LAST_BIT  = DATA_BITS + CFG_BITS;
   localparam int NODE_LSB  = LAST_BIT + 1;
   localparam int STAMP_LSB = NODE_LSB + NODE_BITS;
   localparam int ENTRY_W   = STAMP_LSB + STAMP_BITS;

   typedef enum logic [1:0] {S_IDLE, S_OFFER, S_TREAD, S_TEMIT} state_type;

   state_type             state_ff, state_in;
   req_type               req_ff;
   logic [DEV_W-1:0]      dev_ff;
   logic [IDX_W-1:0]      head_ff [NUM_DEVICES];
   logic [FILL_W-1:0]     fill_ff [NUM_DEVICES];
   logic [CFG_BITS-1:0]   window_ff, window_in;
   logic [STAMP_BITS-1:0] tick_ff, tick_in;
   logic [CFG_BITS-1:0]   accept_cycles_ff;
   logic [CFG_BITS-1:0]   window_cycles_ff;
   logic [CFG_BITS-1:0]   latency_cycles_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff, rsp_in;

   logic                  req_fire;
   logic                  rsp_free;
   logic                  rsp_load;
   logic                  dev_ok;
   logic                  last_dev;
   logic [DEV_W-1:0]      sel_dev;
   logic [IDX_W-1:0]      sel_head;
   logic [FILL_W-1:0]     sel_fill;
   logic [IDX_W:0]        slot_sum;
   logic [IDX_W-1:0]      slot;
   logic [IDX_W-1:0]      head_inc;
   logic [ADDR_W-1:0]     base_addr;
   logic [1:0]            offer_status;
   logic                  offer_ok;
   logic                  eligible;
   logic                  slot_valid;
   logic                  deliver;
   logic [CFG_BITS:0]     window_sum;
   logic                  window_wrap;
   logic [ENTRY_W-1:0]    wr_entry;
   logic [ENTRY_W-1:0]    rd_entry;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign dev_ok   = (32'(req_ff.target_device) < NUM_DEVICES);
   assign last_dev = (dev_ff == DEV_W'(NUM_DEVICES - 1));
   assign sel_dev  = (state_ff == S_OFFER) ? DEV_W'(req_ff.target_device) : dev_ff;
   assign sel_head = head_ff[sel_dev];
   assign sel_fill = fill_ff[sel_dev];

   assign slot_sum = (IDX_W + 1)'(sel_head) + (IDX_W + 1)'(sel_fill);
   assign slot     = (slot_sum >= (IDX_W + 1)'(QUEUE_DEPTH))
                   ? IDX_W'(slot_sum - (IDX_W + 1)'(QUEUE_DEPTH)) : IDX_W'(slot_sum);
   assign head_inc = (sel_head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : sel_head + 1'b1;
   assign base_addr = ADDR_W'(sel_dev) * ADDR_W'(QUEUE_DEPTH);

   always_comb begin
      priority if (window_ff >= accept_cycles_ff) begin
         offer_status = STATUS_REFUSED;
      end else if (!dev_ok || (sel_fill >= FILL_W'(QUEUE_DEPTH))) begin
         offer_status = STATUS_DROPPED;
      end else begin
         offer_status = STATUS_ACCEPTED;
      end
   end

   assign rsp_load = ((state_ff == S_OFFER) || (state_ff == S_TEMIT)) && rsp_free;
   assign offer_ok = (state_ff == S_OFFER) && rsp_free && (offer_status == STATUS_ACCEPTED);

   assign wr_entry = {tick_ff, NODE_BITS'(req_ff.remote_node), req_ff.last_beat,
                      req_ff.user_bits, DATA_BITS'(req_ff.beat_data)};

   idds_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (offer_ok),
      .wr_addr (base_addr + ADDR_W'(slot)),
      .wr_data (wr_entry),
      .rd_addr (base_addr + ADDR_W'(sel_head)),
      .rd_data (rd_entry)
   );

   idds_age_check u_age (
      .now      (tick_ff + 1'b1),
      .stamp    (rd_entry[STAMP_LSB +: STAMP_BITS]),
      .latency  (latency_cycles_ff),
      .eligible (eligible)
   );

   assign slot_valid = (sel_fill != '0) && eligible;
   assign deliver    = (state_ff == S_TEMIT) && rsp_free && slot_valid;

   always_comb begin
      rsp_in = '0;
      if (state_ff == S_OFFER) begin
         rsp_in.kind         = KIND_OFFER;
         rsp_in.offer_status = offer_status;
         rsp_in.end_of_run   = 1'b1;
      end else begin
         rsp_in.kind       = KIND_SLOT;
         rsp_in.port       = 2'(dev_ff);
         rsp_in.end_of_run = last_dev;
         if (slot_valid) begin
            rsp_in.out_valid      = 1'b1;
            rsp_in.out_data       = 64'(rd_entry[DATA_BITS-1:0]);
            rsp_in.out_local_node = 8'(rd_entry[NODE_LSB +: NODE_BITS]);
            rsp_in.out_user       = rd_entry[USER_LSB +: CFG_BITS];
            rsp_in.out_last       = rd_entry[LAST_BIT];
         end
      end
   end

   assign window_sum  = (CFG_BITS + 1)'(window_ff) + 1'b1;
   assign window_wrap = (window_cycles_ff == '0)
                     || (window_sum >= (CFG_BITS + 1)'(window_cycles_ff));

   always_comb begin
      state_in  = state_ff;
      window_in = window_ff;
      tick_in   = tick_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = (req_data.mode == MODE_TICK) ? S_TREAD : S_OFFER;
            end
         end
         S_OFFER: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         S_TREAD: begin
            state_in = S_TEMIT;
         end
         S_TEMIT: begin
            if (rsp_free) begin
               if (last_dev) begin
                  state_in  = S_IDLE;
                  window_in = window_wrap ? '0 : CFG_BITS'(window_sum);
                  tick_in   = tick_ff + 1'b1;
               end else begin
                  state_in = S_TREAD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= '0;
         tick_ff      <= '0;
         dev_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         window_ff <= window_in;
         tick_ff   <= tick_in;
         if (req_fire) begin
            dev_ff <= '0;
         end else if ((state_ff == S_TEMIT) && rsp_free && !last_dev) begin
            dev_ff <= dev_ff + 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         req_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DEVICES; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else if (offer_ok) begin
         fill_ff[sel_dev] <= sel_fill + 1'b1;
      end else if (deliver) begin
         head_ff[sel_dev] <= head_inc;
         fill_ff[sel_dev] <= sel_fill - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accept_cycles_ff  <= CFG_BITS'(1);
         window_cycles_ff  <= CFG_BITS'(1);
         latency_cycles_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACCEPT_CYCLES:  accept_cycles_ff  <= csr_wdata;
            CSR_WINDOW_CYCLES:  window_cycles_ff  <= csr_wdata;
            CSR_LATENCY_CYCLES: latency_cycles_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   `IDDS_ASSERT_SAME(a_fill_bound, state_ff != S_IDLE, sel_fill <= FILL_W'(QUEUE_DEPTH), "fill exceeds depth")
   `IDDS_ASSERT_SAME(a_offer_ends, rsp_load && (rsp_in.kind == KIND_OFFER), rsp_in.end_of_run, "offer result not final")
   `IDDS_ASSERT_NEXT(a_run_end_idle, rsp_load && rsp_in.end_of_run, state_ff == S_IDLE, "sequencer busy after final result")
   `IDDS_ASSERT_NEXT(a_one_item, req_fire, !req_ready, "second word taken while busy")

endmodule
